// ===== sv/salc_pkg.sv =====
// constants and types shared by the lru cache files
package salc_pkg;

   localparam int ADDR_FIELD_W   = 64;
   localparam int COUNT_W        = 32;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 6;
   localparam int SET_BITS_W     = 4;
   localparam int BLOCK_BITS_W   = 6;
   localparam int WAYS_W         = 4;
   localparam int MAX_BLOCK_BITS = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [COUNT_W-1:0]     count_type;

   localparam csr_index_type CSR_SET_BITS   = 2'd0;
   localparam csr_index_type CSR_BLOCK_BITS = 2'd1;
   localparam csr_index_type CSR_WAYS       = 2'd2;

endpackage

// ===== sv/set_assoc_lru_cache_sim.sv =====
// set-associative cache model with true lru replacement, top level
//
// One address word is taken when req_start is high and busy is low. The word is split into
// set and tag, the set's row is read from the line store, and one shared compare unit then
// walks the ways in use one per cycle (ways as clamped into 1..MAX_WAYS), looking for the
// tag, the first free way and the oldest way. The row is then written back. The result is
// on the rsp_ ports for exactly one cycle, marked by rsp_valid, and busy falls in that same
// cycle, so a new word can be taken while the result is shown. The receiver cannot hold
// results off. After reset the line store is swept clean, one set per cycle, through all
// 2**MAX_SET_BITS sets (256 by default) with busy high; csr writes are taken throughout.
// The hit, miss and eviction totals saturate at all ones.
module set_assoc_lru_cache_sim #(
   parameter int MAX_SET_BITS = 8,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   input  logic [salc_pkg::ADDR_FIELD_W-1:0]   req_address,
   output logic                                busy,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic                                rsp_miss,
   output logic                                rsp_evicted,
   output logic [salc_pkg::COUNT_W-1:0]        rsp_hit_count,
   output logic [salc_pkg::COUNT_W-1:0]        rsp_miss_count,
   output logic [salc_pkg::COUNT_W-1:0]        rsp_evict_count,
   input  logic                                csr_we,
   input  logic [salc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import salc_pkg::*;

   localparam int NSETS = 1 << MAX_SET_BITS;
   localparam int SETW  = MAX_SET_BITS;
   localparam int WAYW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int NWW   = $clog2(MAX_WAYS + 1);
   localparam int RANKW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int LIMW  = RANKW + 1;
   localparam int TAGW  = ADDR_WIDTH - 2;
   localparam int SW    = $clog2(MAX_SET_BITS + 1);
   localparam int SHW   = $clog2(MAX_SET_BITS + MAX_BLOCK_BITS + 1);

   localparam logic [RANKW-1:0] RANK_TOP = RANKW'(MAX_WAYS - 1);
   localparam logic [LIMW-1:0]  LIM_ALL  = LIMW'(MAX_WAYS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef logic [MAX_WAYS-1:0][RANKW-1:0] rank_row_type;
   typedef logic [MAX_WAYS-1:0][TAGW-1:0]  tag_row_type;

   // line store, one row per set
   logic [MAX_WAYS-1:0] vld_mem  [NSETS];
   rank_row_type        rank_mem [NSETS];
   tag_row_type         tag_mem  [NSETS];

   state_type             state_ff, state_in;
   logic [SETW-1:0]       clr_ff, clr_in;
   logic [SET_BITS_W-1:0] set_bits_ff, set_bits_in;
   logic [BLOCK_BITS_W-1:0] block_bits_ff, block_bits_in;
   logic [WAYS_W-1:0]     ways_ff, ways_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [SW-1:0]         s_ff, s_in;
   logic [BLOCK_BITS_W-1:0] b_ff, b_in;
   logic [NWW-1:0]        nways_ff, nways_in;
   logic [SETW-1:0]       set_ff, set_in;
   logic [TAGW-1:0]       tag_ff, tag_in;
   logic [WAYW-1:0]       way_ff, way_in;
   logic                  hit_fnd_ff, hit_fnd_in;
   logic [WAYW-1:0]       hit_way_ff, hit_way_in;
   logic [RANKW-1:0]      hit_rank_ff, hit_rank_in;
   logic                  inv_fnd_ff, inv_fnd_in;
   logic [WAYW-1:0]       inv_way_ff, inv_way_in;
   logic [WAYW-1:0]       vic_way_ff, vic_way_in;
   logic [RANKW-1:0]      vic_rank_ff, vic_rank_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   count_type             hit_total_ff, hit_total_in;
   count_type             miss_total_ff, miss_total_in;
   count_type             evict_total_ff, evict_total_in;

   logic [MAX_WAYS-1:0]   vld_rd_ff;
   rank_row_type          rank_rd_ff;
   tag_row_type           tag_rd_ff;

   logic                  mem_we;
   logic [SETW-1:0]       mem_wa;
   logic [MAX_WAYS-1:0]   vld_wd;
   rank_row_type          rank_wd;
   logic                  tag_we;
   tag_row_type           tag_wd;

   logic                  cur_vld;
   logic [TAGW-1:0]       cur_tag;
   logic [RANKW-1:0]      cur_rank;
   logic                  last_way;
   logic [WAYW-1:0]       upd_way;
   logic [LIMW-1:0]       upd_lim;
   logic [SHW-1:0]        tag_shift;

   assign cur_vld   = vld_rd_ff[way_ff];
   assign cur_tag   = tag_rd_ff[way_ff];
   assign cur_rank  = rank_rd_ff[way_ff];
   assign last_way  = (NWW'(way_ff) + NWW'(1)) == nways_ff;
   assign tag_shift = SHW'(s_ff) + SHW'(b_ff);

   // way to make most recent, and the age below which the others grow older
   always_comb begin
      if (hit_fnd_ff) begin
         upd_way = hit_way_ff;
         upd_lim = {1'b0, hit_rank_ff};
      end else if (inv_fnd_ff) begin
         upd_way = inv_way_ff;
         upd_lim = LIM_ALL;
      end else begin
         upd_way = vic_way_ff;
         upd_lim = {1'b0, vic_rank_ff};
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      set_bits_in    = set_bits_ff;
      block_bits_in  = block_bits_ff;
      ways_in        = ways_ff;
      addr_in        = addr_ff;
      s_in           = s_ff;
      b_in           = b_ff;
      nways_in       = nways_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      way_in         = way_ff;
      hit_fnd_in     = hit_fnd_ff;
      hit_way_in     = hit_way_ff;
      hit_rank_in    = hit_rank_ff;
      inv_fnd_in     = inv_fnd_ff;
      inv_way_in     = inv_way_ff;
      vic_way_in     = vic_way_ff;
      vic_rank_in    = vic_rank_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;
      hit_total_in   = hit_total_ff;
      miss_total_in  = miss_total_ff;
      evict_total_in = evict_total_ff;
      mem_we         = 1'b0;
      mem_wa         = set_ff;
      vld_wd         = vld_rd_ff;
      rank_wd        = rank_rd_ff;
      tag_we         = 1'b0;
      tag_wd         = tag_rd_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_in   = csr_wdata[SET_BITS_W-1:0];
            CSR_BLOCK_BITS: block_bits_in = csr_wdata[BLOCK_BITS_W-1:0];
            CSR_WAYS:       ways_in       = csr_wdata[WAYS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            mem_wa  = clr_ff;
            vld_wd  = '0;
            rank_wd = '0;
            clr_in  = clr_ff + SETW'(1);
            if (clr_ff == {SETW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_start) begin
               addr_in = req_address[ADDR_WIDTH-1:0];
               if (set_bits_ff == '0) begin
                  s_in = SW'(1);
               end else if (set_bits_ff > MAX_SET_BITS) begin
                  s_in = SW'(MAX_SET_BITS);
               end else begin
                  s_in = SW'(set_bits_ff);
               end
               if (block_bits_ff == '0) begin
                  b_in = BLOCK_BITS_W'(1);
               end else if (block_bits_ff > MAX_BLOCK_BITS) begin
                  b_in = BLOCK_BITS_W'(MAX_BLOCK_BITS);
               end else begin
                  b_in = block_bits_ff;
               end
               if (ways_ff == '0) begin
                  nways_in = NWW'(1);
               end else if (ways_ff > MAX_WAYS) begin
                  nways_in = NWW'(MAX_WAYS);
               end else begin
                  nways_in = NWW'(ways_ff);
               end
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            set_in   = SETW'(addr_ff >> b_ff) & ~({SETW{1'b1}} << s_ff);
            tag_in   = TAGW'(addr_ff >> tag_shift);
            state_in = ST_READ;
         end
         ST_READ: begin
            way_in     = '0;
            hit_fnd_in = 1'b0;
            inv_fnd_in = 1'b0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (!hit_fnd_ff && cur_vld && cur_tag == tag_ff) begin
               hit_fnd_in  = 1'b1;
               hit_way_in  = way_ff;
               hit_rank_in = cur_rank;
            end
            if (!inv_fnd_ff && !cur_vld) begin
               inv_fnd_in = 1'b1;
               inv_way_in = way_ff;
            end
            if (way_ff == '0 || cur_rank > vic_rank_ff) begin
               vic_way_in  = way_ff;
               vic_rank_in = cur_rank;
            end
            if (last_way) begin
               state_in = ST_UPDATE;
            end else begin
               way_in = way_ff + WAYW'(1);
            end
         end
         ST_UPDATE: begin
            mem_we = 1'b1;
            if (!hit_fnd_ff) begin
               tag_we          = 1'b1;
               tag_wd[upd_way] = tag_ff;
               if (inv_fnd_ff) begin
                  vld_wd[upd_way] = 1'b1;
               end
            end
            for (int i = 0; i < MAX_WAYS; i++) begin
               if (NWW'(i) < nways_ff && WAYW'(i) != upd_way && vld_rd_ff[i] &&
                   {1'b0, rank_rd_ff[i]} < upd_lim && rank_rd_ff[i] < RANK_TOP) begin
                  rank_wd[i] = rank_rd_ff[i] + RANKW'(1);
               end
            end
            rank_wd[upd_way] = '0;
            rsp_valid_in   = 1'b1;
            rsp_hit_in     = hit_fnd_ff;
            rsp_evicted_in = !hit_fnd_ff && !inv_fnd_ff;
            if (hit_fnd_ff) begin
               if (hit_total_ff != '1) begin
                  hit_total_in = hit_total_ff + COUNT_W'(1);
               end
            end else begin
               if (miss_total_ff != '1) begin
                  miss_total_in = miss_total_ff + COUNT_W'(1);
               end
               if (!inv_fnd_ff && evict_total_ff != '1) begin
                  evict_total_in = evict_total_ff + COUNT_W'(1);
               end
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         set_bits_ff    <= SET_BITS_W'(1);
         block_bits_ff  <= BLOCK_BITS_W'(1);
         ways_ff        <= WAYS_W'(1);
         rsp_valid_ff   <= 1'b0;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         set_bits_ff    <= set_bits_in;
         block_bits_ff  <= block_bits_in;
         ways_ff        <= ways_in;
         rsp_valid_ff   <= rsp_valid_in;
         hit_total_ff   <= hit_total_in;
         miss_total_ff  <= miss_total_in;
         evict_total_ff <= evict_total_in;
      end
      addr_ff        <= addr_in;
      s_ff           <= s_in;
      b_ff           <= b_in;
      nways_ff       <= nways_in;
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      way_ff         <= way_in;
      hit_fnd_ff     <= hit_fnd_in;
      hit_way_ff     <= hit_way_in;
      hit_rank_ff    <= hit_rank_in;
      inv_fnd_ff     <= inv_fnd_in;
      inv_way_ff     <= inv_way_in;
      vic_way_ff     <= vic_way_in;
      vic_rank_ff    <= vic_rank_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vld_mem[mem_wa]  <= vld_wd;
         rank_mem[mem_wa] <= rank_wd;
      end
      if (tag_we) begin
         tag_mem[mem_wa] <= tag_wd;
      end
      if (state_ff == ST_READ) begin
         vld_rd_ff  <= vld_mem[set_ff];
         rank_rd_ff <= rank_mem[set_ff];
         tag_rd_ff  <= tag_mem[set_ff];
      end
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_miss        = !rsp_hit_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_hit_count   = hit_total_ff;
   assign rsp_miss_count  = miss_total_ff;
   assign rsp_evict_count = evict_total_ff;

endmodule

// ===== tb/sv/tb_set_assoc_lru_cache_sim.sv =====
// self-checking testbench for the set-associative lru cache top level
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_sim;
   import salc_pkg::*;

   localparam int NUM_SETS  = 256;
   localparam int NUM_WAYS  = 8;
   localparam int NUM_LINES = NUM_SETS * NUM_WAYS;
   localparam int TOP_RANK  = NUM_WAYS - 1;
   localparam csr_index_type CSR_SPARE = 2'd3;

   typedef struct packed {
      logic      hit;
      logic      miss;
      logic      evicted;
      count_type hit_count;
      count_type miss_count;
      count_type evict_count;
   } access_outcome_type;

   logic                      clock;
   logic                      reset;
   logic                      req_start;
   logic [ADDR_FIELD_W-1:0]   req_address;
   logic                      busy;
   logic                      rsp_valid;
   logic                      rsp_hit;
   logic                      rsp_miss;
   logic                      rsp_evicted;
   logic [COUNT_W-1:0]        rsp_hit_count;
   logic [COUNT_W-1:0]        rsp_miss_count;
   logic [COUNT_W-1:0]        rsp_evict_count;
   logic                      csr_we;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   // mirror of the cache contents and settings
   logic                      shadow_valid [NUM_LINES];
   logic [63:0]               shadow_tag   [NUM_LINES];
   logic [2:0]                shadow_rank  [NUM_LINES];
   count_type                 hits_seen;
   count_type                 misses_seen;
   count_type                 evicts_seen;
   logic [SET_BITS_W-1:0]     cfg_set_bits;
   logic [BLOCK_BITS_W-1:0]   cfg_block_bits;
   logic [WAYS_W-1:0]         cfg_ways;

   access_outcome_type        pending_outcomes [$];
   access_outcome_type        want;
   int                        error_count;
   bit                        burst_mode;

   set_assoc_lru_cache_sim u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_start       (req_start),
      .req_address     (req_address),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_miss        (rsp_miss),
      .rsp_evicted     (rsp_evicted),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_miss_count  (rsp_miss_count),
      .rsp_evict_count (rsp_evict_count),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int clamp_int(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int eff_set_bits();
      return clamp_int(int'(cfg_set_bits), 1, 8);
   endfunction

   function automatic int eff_block_bits();
      return clamp_int(int'(cfg_block_bits), 1, MAX_BLOCK_BITS);
   endfunction

   function automatic int eff_ways();
      return clamp_int(int'(cfg_ways), 1, NUM_WAYS);
   endfunction

   function automatic count_type bump(count_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // make one way most recent, ageing the valid ways younger than limit
   function automatic void promote_way(int base, int nways, int w, int limit);
      for (int i = 0; i < nways; i++) begin
         if (i != w && shadow_valid[base+i] && int'(shadow_rank[base+i]) < limit &&
             int'(shadow_rank[base+i]) < TOP_RANK)
            shadow_rank[base+i] = shadow_rank[base+i] + 3'd1;
      end
      shadow_rank[base+w] = 3'd0;
   endfunction

   function automatic access_outcome_type predict_access(logic [63:0] addr);
      access_outcome_type res;
      int              s;
      int              b;
      int              nways;
      int              base;
      int              hit_way;
      int              slot;
      int              victim;
      logic [63:0]     tag_v;
      logic [63:0]     set_v;
      s       = eff_set_bits();
      b       = eff_block_bits();
      nways   = eff_ways();
      set_v   = (addr >> b) & ((64'd1 << s) - 64'd1);
      tag_v   = addr >> (s + b);
      base    = int'(set_v) * NUM_WAYS;
      hit_way = -1;
      res     = '0;
      for (int i = 0; i < nways; i++) begin
         if (hit_way < 0 && shadow_valid[base+i] && shadow_tag[base+i] == tag_v)
            hit_way = i;
      end
      if (hit_way >= 0) begin
         promote_way(base, nways, hit_way, int'(shadow_rank[base+hit_way]));
         hits_seen = bump(hits_seen);
         res.hit   = 1'b1;
      end else begin
         misses_seen = bump(misses_seen);
         res.miss    = 1'b1;
         slot        = nways;
         for (int i = 0; i < nways; i++) begin
            if (slot == nways && !shadow_valid[base+i])
               slot = i;
         end
         if (slot < nways) begin
            shadow_valid[base+slot] = 1'b1;
            shadow_tag[base+slot]   = tag_v;
            promote_way(base, nways, slot, NUM_WAYS);
         end else begin
            victim = 0;
            for (int i = 1; i < nways; i++) begin
               if (shadow_rank[base+i] > shadow_rank[base+victim])
                  victim = i;
            end
            shadow_tag[base+victim] = tag_v;
            promote_way(base, nways, victim, int'(shadow_rank[base+victim]));
            evicts_seen = bump(evicts_seen);
            res.evicted = 1'b1;
         end
      end
      res.hit_count   = hits_seen;
      res.miss_count  = misses_seen;
      res.evict_count = evicts_seen;
      return res;
   endfunction

   function automatic logic [63:0] build_address(logic [63:0] tag_v, int set_v,
                                                 logic [63:0] offset);
      int s;
      int b;
      s = eff_set_bits();
      b = eff_block_bits();
      return (tag_v << (s + b)) | (64'(set_v) << b) | (offset & ((64'd1 << b) - 64'd1));
   endfunction

   function automatic logic [63:0] rand_word64();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 50)
         $display("ERROR at %0t: %s", $time, what);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit %b, want %b", rsp_hit, want.hit));
            if (rsp_miss !== want.miss)
               report_mismatch($sformatf("miss %b, want %b", rsp_miss, want.miss));
            if (rsp_evicted !== want.evicted)
               report_mismatch($sformatf("evicted %b, want %b", rsp_evicted, want.evicted));
            if (rsp_hit_count !== want.hit_count)
               report_mismatch($sformatf("hit_count %0d, want %0d",
                                         rsp_hit_count, want.hit_count));
            if (rsp_miss_count !== want.miss_count)
               report_mismatch($sformatf("miss_count %0d, want %0d",
                                         rsp_miss_count, want.miss_count));
            if (rsp_evict_count !== want.evict_count)
               report_mismatch($sformatf("evict_count %0d, want %0d",
                                         rsp_evict_count, want.evict_count));
         end
      end
   end

   task automatic send_access(input logic [63:0] addr);
      bit taken;
      taken = 1'b0;
      @(negedge clock);
      req_start   <= 1'b1;
      req_address <= addr;
      while (!taken) begin
         @(posedge clock);
         if (busy === 1'b0)
            taken = 1'b1;
      end
      pending_outcomes.push_back(predict_access(addr));
   endtask

   task automatic pause_requests(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic access_and_pause(input logic [63:0] addr);
      send_access(addr);
      pause_requests(pick_gap());
   endtask

   task automatic drain_outcomes();
      @(negedge clock);
      req_start <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_SET_BITS:   cfg_set_bits   = data[SET_BITS_W-1:0];
         CSR_BLOCK_BITS: cfg_block_bits = data[BLOCK_BITS_W-1:0];
         CSR_WAYS:       cfg_ways       = data[WAYS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_geometry(input int s, input int b, input int w);
      drain_outcomes();
      write_csr(CSR_SET_BITS, CSR_DATA_W'(s));
      write_csr(CSR_BLOCK_BITS, CSR_DATA_W'(b));
      write_csr(CSR_WAYS, CSR_DATA_W'(w));
   endtask

   // default geometry: one set bit, one block bit, direct mapped
   task automatic test_reset_geometry();
      access_and_pause(64'h0);
      access_and_pause(64'h0);
      access_and_pause(64'h1);
      access_and_pause('1);
      access_and_pause(64'h4);
      access_and_pause(64'h0);
   endtask

   // zero and oversized register values saturate, set fills then lru eviction
   task automatic test_register_limits();
      set_geometry(0, 0, 0);
      access_and_pause(64'h2);
      access_and_pause(64'h8000_0000_0000_0000);
      drain_outcomes();
      write_csr(CSR_SET_BITS, 6'h3F);
      write_csr(CSR_BLOCK_BITS, 6'h3F);
      write_csr(CSR_WAYS, 6'h2F);
      for (int t = 1; t <= 8; t++)
         access_and_pause(build_address(64'(t), 8'h5A, 64'h3));
      access_and_pause(build_address(64'd3, 8'h5A, 64'h0));
      access_and_pause(build_address(64'd9, 8'h5A, 64'h0));
      access_and_pause(build_address(64'd1, 8'h5A, 64'h0));
      access_and_pause('1);
   endtask

   // a write to the spare index leaves the geometry alone
   task automatic test_unknown_index();
      drain_outcomes();
      write_csr(CSR_SPARE, 6'h01);
      access_and_pause(build_address(64'd9, 8'h5A, 64'h0));
      access_and_pause(build_address(64'd4, 8'h5A, 64'h0));
   endtask

   // phases of pooled tags over a few sets, with some fully random words
   task automatic test_random_phases();
      logic [63:0] tag_pool [16];
      int          pool_size;
      int          set_span;
      int          set_base;
      int          s;
      int          w;
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0:       set_geometry(1, 1, 1);
            1:       set_geometry(8, 32, 8);
            2:       set_geometry(15, 63, 15);
            3:       set_geometry(0, 0, 0);
            4:       set_geometry(8, 1, 2);
            5:       set_geometry(1, 32, 8);
            default: set_geometry($urandom_range(0, 15), $urandom_range(0, 63),
                                  $urandom_range(0, 15));
         endcase
         burst_mode = (ph % 3 == 2);
         s          = eff_set_bits();
         w          = eff_ways();
         pool_size  = clamp_int(w + $urandom_range(0, 3), 1, 16);
         for (int i = 0; i < pool_size; i++)
            tag_pool[i] = rand_word64();
         set_span = clamp_int(1 << s, 1, 4);
         set_base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << s) - 1) : 0;
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 99) < 15)
               access_and_pause(rand_word64());
            else
               access_and_pause(build_address(tag_pool[$urandom_range(0, pool_size - 1)],
                                              (set_base + $urandom_range(0, set_span - 1)) %
                                              (1 << s), rand_word64()));
         end
         burst_mode = 1'b0;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_start   = 1'b0;
      req_address = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_SET_BITS;
      csr_wdata   = '0;
      error_count = 0;
      burst_mode  = 1'b0;
      hits_seen   = '0;
      misses_seen = '0;
      evicts_seen = '0;
      cfg_set_bits   = 4'd1;
      cfg_block_bits = 6'd1;
      cfg_ways       = 4'd1;
      for (int i = 0; i < NUM_LINES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_tag[i]   = '0;
         shadow_rank[i]  = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_register_limits();
      test_unknown_index();
      test_random_phases();

      drain_outcomes();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
